@@ hw/rtl/psd_pkg.sv @@
`default_nettype none

package psd_pkg;

    // Default coordinate width, two's complement.
    localparam int COORD_BITS_DEF = 16;

    // Per-item status that travels alongside the arithmetic.
    typedef struct packed {
        logic degen;
        logic in_seg;
    } psd_flags_t;

endpackage

`default_nettype wire

@@ hw/rtl/psd_front.sv @@
`default_nettype none

// Differences, dot products, segment test and the square of the dot product.
module psd_front #(
    parameter int COORD_BITS = psd_pkg::COORD_BITS_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [9*COORD_BITS-1:0]   in_coord,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [4*COORD_BITS+3:0]        out_prod,
    output logic [2*COORD_BITS+1:0]        out_dd,
    output logic [2*COORD_BITS+1:0]        out_ww,
    output psd_pkg::psd_flags_t            out_flags
);
    localparam int CB = COORD_BITS;
    localparam int DW = CB + 1;
    localparam int SW = 2 * CB + 2;
    localparam int LW = (SW + 1) / 2;
    localparam int HW = SW - LW;
    localparam int NS = 6;

    logic [NS-1:0] v_reg;
    logic [NS:0]   rdy;

    assign rdy[NS] = out_ready;
    for (genvar i = 0; i < NS; i++) begin : g_rdy
        assign rdy[i] = !v_reg[i] || rdy[i+1];
    end

    assign in_ready  = rdy[0];
    assign out_valid = v_reg[NS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < NS; i++)
            begin
                if (rdy[i])
                begin
                    v_reg[i] <= (i == 0) ? in_valid : v_reg[(i == 0) ? 0 : i - 1];
                end
            end
        end
    end

    // Stage 0: w = P - S and d = E - S.
    logic signed [DW-1:0] w_reg [3];
    logic signed [DW-1:0] d_reg [3];
    logic signed [DW-1:0] w_next [3];
    logic signed [DW-1:0] d_next [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            w_next[k] = $signed({in_coord[k*CB+CB-1], in_coord[k*CB +: CB]})
                      - $signed({in_coord[(k+3)*CB+CB-1], in_coord[(k+3)*CB +: CB]});
            d_next[k] = $signed({in_coord[(k+6)*CB+CB-1], in_coord[(k+6)*CB +: CB]})
                      - $signed({in_coord[(k+3)*CB+CB-1], in_coord[(k+3)*CB +: CB]});
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            w_reg <= w_next;
            d_reg <= d_next;
        end
    end

    // Stage 1: component products.
    logic signed [SW-1:0] sqw_reg [3];
    logic signed [SW-1:0] sqd_reg [3];
    logic signed [SW-1:0] wd_reg  [3];

    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            for (int k = 0; k < 3; k++)
            begin
                sqw_reg[k] <= w_reg[k] * w_reg[k];
                sqd_reg[k] <= d_reg[k] * d_reg[k];
                wd_reg[k]  <= w_reg[k] * d_reg[k];
            end
        end
    end

    // Stage 2: sums over the three axes.
    logic [SW-1:0]        ww2_reg;
    logic [SW-1:0]        dd2_reg;
    logic signed [SW:0]   dot2_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[2])
        begin
            ww2_reg  <= $unsigned(sqw_reg[0]) + $unsigned(sqw_reg[1])
                      + $unsigned(sqw_reg[2]);
            dd2_reg  <= $unsigned(sqd_reg[0]) + $unsigned(sqd_reg[1])
                      + $unsigned(sqd_reg[2]);
            dot2_reg <= $signed({wd_reg[0][SW-1], wd_reg[0]})
                      + $signed({wd_reg[1][SW-1], wd_reg[1]})
                      + $signed({wd_reg[2][SW-1], wd_reg[2]});
        end
    end

    // Stage 3: degenerate and in-segment tests. The dot product is zeroed
    // for items that need no distance, and the divisor is kept non-zero.
    logic [SW-1:0]        ww3_reg;
    logic [SW-1:0]        dd3_reg;
    logic [SW-1:0]        dot3_reg;
    psd_pkg::psd_flags_t  fl3_reg;
    psd_pkg::psd_flags_t  fl3_next;

    always_comb
    begin
        fl3_next.degen  = (dd2_reg == '0);
        fl3_next.in_seg = !fl3_next.degen && !dot2_reg[SW]
                        && (dot2_reg[SW-1:0] <= dd2_reg);
    end

    always_ff @(posedge clk)
    begin
        if (rdy[3])
        begin
            ww3_reg  <= ww2_reg;
            dd3_reg  <= fl3_next.degen ? SW'(1) : dd2_reg;
            dot3_reg <= fl3_next.in_seg ? dot2_reg[SW-1:0] : '0;
            fl3_reg  <= fl3_next;
        end
    end

    // Stage 4: partial products of the squared dot product.
    logic [2*HW-1:0]      hh_reg;
    logic [HW+LW-1:0]     hl_reg;
    logic [2*LW-1:0]      ll_reg;
    logic [SW-1:0]        ww4_reg;
    logic [SW-1:0]        dd4_reg;
    psd_pkg::psd_flags_t  fl4_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[4])
        begin
            hh_reg  <= dot3_reg[SW-1:LW] * dot3_reg[SW-1:LW];
            hl_reg  <= dot3_reg[SW-1:LW] * dot3_reg[LW-1:0];
            ll_reg  <= dot3_reg[LW-1:0] * dot3_reg[LW-1:0];
            ww4_reg <= ww3_reg;
            dd4_reg <= dd3_reg;
            fl4_reg <= fl3_reg;
        end
    end

    // Stage 5: recombine the partial products.
    logic [2*SW-1:0]      prod5_reg;
    logic [SW-1:0]        ww5_reg;
    logic [SW-1:0]        dd5_reg;
    psd_pkg::psd_flags_t  fl5_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[5])
        begin
            prod5_reg <= ((2*SW)'(hh_reg) << (2*LW)) + ((2*SW)'(hl_reg) << (LW+1))
                       + (2*SW)'(ll_reg);
            ww5_reg   <= ww4_reg;
            dd5_reg   <= dd4_reg;
            fl5_reg   <= fl4_reg;
        end
    end

    assign out_prod  = prod5_reg;
    assign out_dd    = dd5_reg;
    assign out_ww    = ww5_reg;
    assign out_flags = fl5_reg;

endmodule

`default_nettype wire

@@ hw/rtl/psd_div.sv @@
`default_nettype none

// Restoring divider, one quotient bit per stage.
module psd_div #(
    parameter int COORD_BITS = psd_pkg::COORD_BITS_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [4*COORD_BITS+3:0]   in_prod,
    input  wire logic [2*COORD_BITS+1:0]   in_dd,
    input  wire logic [2*COORD_BITS+1:0]   in_ww,
    input  wire psd_pkg::psd_flags_t       in_flags,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [2*COORD_BITS+1:0]        out_quot,
    output logic                           out_rem_nz,
    output logic [2*COORD_BITS+1:0]        out_ww,
    output psd_pkg::psd_flags_t            out_flags
);
    localparam int SW = 2 * COORD_BITS + 2;
    localparam int NS = SW;

    logic [NS-1:0]        v_reg;
    logic [NS:0]          rdy;
    logic [2*SW-1:0]      rq_reg [NS];
    logic [SW-1:0]        dd_reg [NS];
    logic [SW-1:0]        ww_reg [NS];
    psd_pkg::psd_flags_t  fl_reg [NS];

    assign rdy[NS]   = out_ready;
    assign in_ready  = rdy[0];
    assign out_valid = v_reg[NS-1];

    for (genvar j = 0; j < NS; j++) begin : g_stage
        logic [2*SW-1:0]      rq_src;
        logic [SW-1:0]        dd_src;
        logic [SW-1:0]        ww_src;
        psd_pkg::psd_flags_t  fl_src;
        logic                 v_src;
        logic [SW:0]          rem_sh;
        logic [SW:0]          rem_sub;
        logic [2*SW-1:0]      rq_next;

        if (j == 0) begin : g_first
            assign rq_src = in_prod;
            assign dd_src = in_dd;
            assign ww_src = in_ww;
            assign fl_src = in_flags;
            assign v_src  = in_valid;
        end else begin : g_rest
            assign rq_src = rq_reg[j-1];
            assign dd_src = dd_reg[j-1];
            assign ww_src = ww_reg[j-1];
            assign fl_src = fl_reg[j-1];
            assign v_src  = v_reg[j-1];
        end

        assign rdy[j] = !v_reg[j] || rdy[j+1];

        always_comb
        begin
            rem_sh  = rq_src[2*SW-1:SW-1];
            rem_sub = rem_sh - {1'b0, dd_src};
            if (rem_sh >= {1'b0, dd_src})
            begin
                rq_next = {rem_sub[SW-1:0], rq_src[SW-2:0], 1'b1};
            end
            else
            begin
                rq_next = {rem_sh[SW-1:0], rq_src[SW-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[j] <= 1'b0;
            end
            else if (rdy[j])
            begin
                v_reg[j] <= v_src;
            end
        end

        always_ff @(posedge clk)
        begin
            if (rdy[j])
            begin
                rq_reg[j] <= rq_next;
                dd_reg[j] <= dd_src;
                ww_reg[j] <= ww_src;
                fl_reg[j] <= fl_src;
            end
        end
    end

    assign out_quot   = rq_reg[NS-1][SW-1:0];
    assign out_rem_nz = (rq_reg[NS-1][2*SW-1:SW] != '0);
    assign out_ww     = ww_reg[NS-1];
    assign out_flags  = fl_reg[NS-1];

endmodule

`default_nettype wire

@@ hw/rtl/psd_sqrt.sv @@
`default_nettype none

// Squared distance from the quotient, then a digit-by-digit integer root.
module psd_sqrt #(
    parameter int COORD_BITS = psd_pkg::COORD_BITS_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [2*COORD_BITS+1:0]   in_quot,
    input  wire logic                      in_rem_nz,
    input  wire logic [2*COORD_BITS+1:0]   in_ww,
    input  wire psd_pkg::psd_flags_t       in_flags,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [COORD_BITS:0]            out_root,
    output psd_pkg::psd_flags_t            out_flags
);
    localparam int SW = 2 * COORD_BITS + 2;
    localparam int RW = COORD_BITS + 1;
    localparam int NS = RW + 1;

    logic [NS-1:0]        v_reg;
    logic [NS:0]          rdy;
    logic [SW-1:0]        rem_reg  [NS];
    logic [RW-1:0]        root_reg [NS];
    psd_pkg::psd_flags_t  fl_reg   [NS];

    assign rdy[NS]   = out_ready;
    assign in_ready  = rdy[0];
    assign out_valid = v_reg[NS-1];

    for (genvar i = 0; i < NS; i++) begin : g_rdy
        assign rdy[i] = !v_reg[i] || rdy[i+1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i] <= 1'b0;
            end
            else if (rdy[i])
            begin
                v_reg[i] <= (i == 0) ? in_valid : v_reg[(i == 0) ? 0 : i - 1];
            end
        end
    end

    // Stage 0: floor(num / dd) = ww - ceil(dot^2 / dd); zero unless in segment.
    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            rem_reg[0]  <= in_flags.in_seg ? (in_ww - in_quot - SW'(in_rem_nz)) : '0;
            root_reg[0] <= '0;
            fl_reg[0]   <= in_flags;
        end
    end

    for (genvar i = 1; i < NS; i++) begin : g_root
        localparam int B = NS - 1 - i;
        logic [SW-1:0] trial;

        assign trial = (SW'(root_reg[i-1]) << (B + 1)) | (SW'(1) << (2 * B));

        always_ff @(posedge clk)
        begin
            if (rdy[i])
            begin
                fl_reg[i] <= fl_reg[i-1];
                if (rem_reg[i-1] >= trial)
                begin
                    rem_reg[i]  <= rem_reg[i-1] - trial;
                    root_reg[i] <= root_reg[i-1] | (RW'(1) << B);
                end
                else
                begin
                    rem_reg[i]  <= rem_reg[i-1];
                    root_reg[i] <= root_reg[i-1];
                end
            end
        end
    end

    assign out_root  = root_reg[NS-1];
    assign out_flags = fl_reg[NS-1];

endmodule

`default_nettype wire

@@ hw/rtl/point_segment_distance_3d.sv @@
`default_nettype none

// Channel   Direction  tdata (lowest bit first)                       tuser
// s_axis    in         point_x/y/z, start_x/y/z, end_x/y/z            -
// m_axis    out        distance, zero fill to whole bytes             in_segment, degenerate
//
// The block is a single pipeline that accepts one transfer in every cycle while
// no stall on the output holds it up, and returns one result per query after
// the front stages of products and sums, one divider stage per quotient bit
// and one root stage per result bit. Each stage holds its own valid bit and
// takes new data whenever it is empty or its successor moves, so bubbles close
// up and a stall on the output loses or repeats nothing. The asynchronous reset
// clears only the valid bits; the data registers need no reset.
module point_segment_distance_3d #(
    parameter int COORD_BITS = psd_pkg::COORD_BITS_DEF
) (
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    input  wire logic                                     s_tvalid,
    output logic                                          s_tready,
    // point_x, point_y, point_z, start_x, start_y, start_z, end_x, end_y, end_z
    input  wire logic [((9*COORD_BITS+7)/8)*8-1:0]        s_tdata,
    output logic                                          m_tvalid,
    input  wire logic                                     m_tready,
    // distance
    output logic [((COORD_BITS+8)/8)*8-1:0]               m_tdata,
    // in_segment, degenerate
    output logic [1:0]                                    m_tuser
);
    localparam int SW     = 2 * COORD_BITS + 2;
    localparam int RW     = COORD_BITS + 1;
    localparam int OUT_TW = ((COORD_BITS + 8) / 8) * 8;

    logic                 f_valid;
    logic                 f_ready;
    logic [2*SW-1:0]      f_prod;
    logic [SW-1:0]        f_dd;
    logic [SW-1:0]        f_ww;
    psd_pkg::psd_flags_t  f_flags;

    logic                 d_valid;
    logic                 d_ready;
    logic [SW-1:0]        d_quot;
    logic                 d_rem_nz;
    logic [SW-1:0]        d_ww;
    psd_pkg::psd_flags_t  d_flags;

    logic [RW-1:0]        root;
    psd_pkg::psd_flags_t  r_flags;

    psd_front #(.COORD_BITS(COORD_BITS)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_coord  (s_tdata[9*COORD_BITS-1:0]),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_prod  (f_prod),
        .out_dd    (f_dd),
        .out_ww    (f_ww),
        .out_flags (f_flags)
    );

    // Quotient of the squared dot product over the squared segment length, with a flag for a non-zero remainder.
    psd_div #(.COORD_BITS(COORD_BITS)) u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (f_valid),
        .in_ready   (f_ready),
        .in_prod    (f_prod),
        .in_dd      (f_dd),
        .in_ww      (f_ww),
        .in_flags   (f_flags),
        .out_valid  (d_valid),
        .out_ready  (d_ready),
        .out_quot   (d_quot),
        .out_rem_nz (d_rem_nz),
        .out_ww     (d_ww),
        .out_flags  (d_flags)
    );

    // The last root stage doubles as the output register.
    psd_sqrt #(.COORD_BITS(COORD_BITS)) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (d_valid),
        .in_ready  (d_ready),
        .in_quot   (d_quot),
        .in_rem_nz (d_rem_nz),
        .in_ww     (d_ww),
        .in_flags  (d_flags),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_root  (root),
        .out_flags (r_flags)
    );

    assign m_tdata = OUT_TW'(root);
    assign m_tuser = {r_flags.degen, r_flags.in_seg};

endmodule

`default_nettype wire

@@ test/testbench.sv @@
`timescale 1ns / 1ps

// Checks the point to segment distance pipeline against an exact integer model.
// A directed table covers extremes and special cases, then random queries follow,
// mostly well-formed segments with points placed near them, the rest raw noise.
module testbench;

    localparam int CB = psd_pkg::COORD_BITS_DEF;
    localparam int IN_W = ((9*CB+7)/8)*8;
    localparam int OUT_W = ((CB+8)/8)*8;
    localparam int LATENCY = 3*CB+10;
    localparam logic [16:0] DIST_MAX = 17'h1FFFF;

    typedef struct packed {
        logic        in_seg;
        logic        degen;
        logic [16:0] distance;
    } dist_result_t;

    logic               clk;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [IN_W-1:0]    s_tdata;
    logic               m_tvalid;
    logic               m_tready;
    logic [OUT_W-1:0]   m_tdata;
    logic [1:0]         m_tuser;

    dist_result_t       pending_results[$];
    int                 error_count;
    bit                 hold_off;
    bit                 stimulus_done;

    point_segment_distance_3d DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Exact prediction. The widest term, |w|^2*|d|^2, is below 2^72 and r*r*dd
    // stays below 2^72 too, so 160-bit arithmetic holds every value exactly.
    function automatic dist_result_t predict_distance(input logic [IN_W-1:0] q);
        logic signed [159:0] w, d, ww, dd, dot, num, t2;
        logic [17:0] r, trial;
        dist_result_t res;
        ww = 0;
        dd = 0;
        dot = 0;
        res = '0;
        for (int k = 0; k < 3; k++)
        begin
            w = $signed(q[k*CB +: CB]) - $signed(q[(3+k)*CB +: CB]);
            d = $signed(q[(6+k)*CB +: CB]) - $signed(q[(3+k)*CB +: CB]);
            ww += w * w;
            dd += d * d;
            dot += w * d;
        end
        if (dd == 0)
        begin
            res.degen = 1'b1;
            return res;
        end
        if (dot < 0 || dot > dd)
            return res;
        num = ww * dd - dot * dot;
        r = '0;
        for (int b = CB + 1; b >= 0; b--)
        begin
            trial = r | (18'd1 << b);
            t2 = $signed({142'd0, trial});
            if (t2 * t2 * dd <= num)
                r = trial;
        end
        res.in_seg = 1'b1;
        res.distance = (r > DIST_MAX) ? DIST_MAX : r[16:0];
        return res;
    endfunction

    function automatic logic [IN_W-1:0] pack_query(input logic [15:0] c[9]);
        logic [IN_W-1:0] q;
        q = '0;
        for (int k = 0; k < 9; k++)
            q[k*CB +: CB] = c[k];
        return q;
    endfunction

    // Sends one transfer; valid stays high across back-to-back transfers.
    task automatic send_query(input logic [IN_W-1:0] q);
        s_tvalid <= 1'b1;
        s_tdata <= q;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_results.push_back(predict_distance(q));
        @(negedge clk);
    endtask

    task automatic idle_sender(input int cycles);
        s_tvalid <= 1'b0;
        s_tdata <= {IN_W{1'b0}};
        repeat (cycles) @(negedge clk);
    endtask

    task automatic send_with_gaps(input logic [IN_W-1:0] q, inout int burst_left);
        if (burst_left == 0)
        begin
            idle_sender($urandom_range(0, 6));
            burst_left = $urandom_range(1, 20);
        end
        send_query(q);
        burst_left--;
    endtask

    function automatic logic [IN_W-1:0] random_query();
        logic [15:0] c[9];
        int mode;
        int span;
        mode = $urandom_range(0, 9);
        span = (mode < 3) ? 255 : 4095;
        for (int k = 0; k < 9; k++)
            c[k] = 16'($urandom());
        if (mode == 9)
            return pack_query(c);
        if (mode < 7)
        begin
            // Segment and point kept close so that the foot often lands inside.
            for (int k = 0; k < 3; k++)
            begin
                c[6+k] = c[3+k] + 16'($urandom_range(0, 2*span)) - 16'(span);
                c[k] = c[3+k] + ((c[6+k] - c[3+k]) >>> 1)
                       + 16'($urandom_range(0, 2*span)) - 16'(span);
            end
        end
        if ($urandom_range(0, 4) == 0)
        begin
            c[2] = '0;
            c[5] = '0;
            c[8] = '0;
        end
        if ($urandom_range(0, 19) == 0)
            for (int k = 0; k < 3; k++)
                c[6+k] = c[3+k];
        return pack_query(c);
    endfunction

    // Result checking against the oldest prediction.
    always @(posedge clk)
    begin
        dist_result_t got, want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.in_seg = m_tuser[0];
            got.degen = m_tuser[1];
            got.distance = m_tdata[16:0];
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, got);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.in_seg !== want.in_seg)
                begin
                    $display("%0t: in_segment expected %b actual %b", $time, want.in_seg,
                             got.in_seg);
                    error_count++;
                end
                if (got.degen !== want.degen)
                begin
                    $display("%0t: degenerate expected %b actual %b", $time, want.degen,
                             got.degen);
                    error_count++;
                end
                if (got.distance !== want.distance)
                begin
                    $display("%0t: distance expected %h actual %h", $time, want.distance,
                             got.distance);
                    error_count++;
                end
                if (m_tdata[OUT_W-1:17] !== '0)
                begin
                    $display("%0t: tdata fill expected 0 actual %h", $time,
                             m_tdata[OUT_W-1:17]);
                    error_count++;
                end
            end
        end
    end

    // The receiver stalls on its own pattern, with a long hold-off on request.
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_off)
            m_tready <= 1'b0;
        else if (($time / 2000) % 3 == 0)
            m_tready <= 1'b1;
        else
            m_tready <= ($urandom_range(0, 3) != 0);
    end

    initial
    begin
        hold_off = 1'b0;
        wait (stimulus_done === 1'b0);
        @(posedge rst_n);
        repeat (300) @(negedge clk);
        hold_off = 1'b1;
        repeat (200) @(negedge clk);
        hold_off = 1'b0;
    end

    initial
    begin
        #20ms;
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        logic [15:0] c[9];
        logic [IN_W-1:0] q;
        dist_result_t want;
        int burst_left;
        int settle;
        // Directed queries: point, start, end; typed result or predictor.
        typedef struct {
            logic [15:0] pt[3];
            logic [15:0] st[3];
            logic [15:0] en[3];
            bit          typed;
            dist_result_t res;
        } query_row_t;
        query_row_t rows[16] = '{
            // Degenerate segment at zero and at the extremes.
            '{'{16'h0100, 16'h0, 16'h0}, '{16'h0, 16'h0, 16'h0}, '{16'h0, 16'h0, 16'h0},
              1'b1, '{1'b0, 1'b1, 17'd0}},
            '{'{16'h8000, 16'h8000, 16'h8000}, '{16'h7FFF, 16'h7FFF, 16'h7FFF},
              '{16'h7FFF, 16'h7FFF, 16'h7FFF}, 1'b1, '{1'b0, 1'b1, 17'd0}},
            // Point on the start, on the end, and past either end.
            '{'{16'h0, 16'h0, 16'h0}, '{16'h0, 16'h0, 16'h0}, '{16'h0100, 16'h0, 16'h0},
              1'b1, '{1'b1, 1'b0, 17'd0}},
            '{'{16'h0100, 16'h0, 16'h0}, '{16'h0, 16'h0, 16'h0}, '{16'h0100, 16'h0, 16'h0},
              1'b1, '{1'b1, 1'b0, 17'd0}},
            '{'{16'hFF00, 16'h0, 16'h0}, '{16'h0, 16'h0, 16'h0}, '{16'h0100, 16'h0, 16'h0},
              1'b1, '{1'b0, 1'b0, 17'd0}},
            '{'{16'h0200, 16'h0, 16'h0}, '{16'h0, 16'h0, 16'h0}, '{16'h0100, 16'h0, 16'h0},
              1'b1, '{1'b0, 1'b0, 17'd0}},
            // Unit offset from the middle: distance 1.0 in each axis pair.
            '{'{16'h0080, 16'h0100, 16'h0}, '{16'h0, 16'h0, 16'h0}, '{16'h0100, 16'h0, 16'h0},
              1'b1, '{1'b1, 1'b0, 17'h00100}},
            '{'{16'h0, 16'h0080, 16'hFF00}, '{16'h0, 16'h0, 16'h0}, '{16'h0, 16'h0100, 16'h0},
              1'b1, '{1'b1, 1'b0, 17'h00100}},
            // Longest segments and farthest points.
            '{'{16'h0, 16'h7FFF, 16'h7FFF}, '{16'h8000, 16'h8000, 16'h8000},
              '{16'h7FFF, 16'h8000, 16'h8000}, 1'b0, '{1'b0, 1'b0, 17'd0}},
            '{'{16'h0, 16'h8000, 16'h8000}, '{16'h8000, 16'h7FFF, 16'h7FFF},
              '{16'h7FFF, 16'h7FFF, 16'h7FFF}, 1'b0, '{1'b0, 1'b0, 17'd0}},
            '{'{16'h7FFF, 16'h8000, 16'h7FFF}, '{16'h8000, 16'h8000, 16'h8000},
              '{16'h7FFF, 16'h7FFF, 16'h8000}, 1'b0, '{1'b0, 1'b0, 17'd0}},
            '{'{16'h8000, 16'h7FFF, 16'h8000}, '{16'h7FFF, 16'h7FFF, 16'h7FFF},
              '{16'h8000, 16'h8000, 16'h7FFF}, 1'b0, '{1'b0, 1'b0, 17'd0}},
            // Diagonal segment, two-dimensional query, fractional distance.
            '{'{16'h0000, 16'h0100, 16'h0}, '{16'h0, 16'h0, 16'h0}, '{16'h0100, 16'h0100, 16'h0},
              1'b0, '{1'b0, 1'b0, 17'd0}},
            '{'{16'h0003, 16'hFFFD, 16'h0001}, '{16'hFFFF, 16'h0001, 16'h0},
              '{16'h0005, 16'h0002, 16'hFFFF}, 1'b0, '{1'b0, 1'b0, 17'd0}},
            // Shortest non-degenerate segment: one LSB in Z; then a point midway along a two-LSB segment.
            '{'{16'h5555, 16'hAAAA, 16'h0000}, '{16'h1234, 16'h4321, 16'h0000},
              '{16'h1234, 16'h4321, 16'h0001}, 1'b0, '{1'b0, 1'b0, 17'd0}},
            '{'{16'h1234, 16'h4321, 16'h0000}, '{16'h1234, 16'h4321, 16'hFFFF},
              '{16'h1234, 16'h4321, 16'h0001}, 1'b1, '{1'b1, 1'b0, 17'd0}}
        };

        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        error_count = 0;
        stimulus_done = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (rows[i])
        begin
            for (int k = 0; k < 3; k++)
            begin
                c[k] = rows[i].pt[k];
                c[3+k] = rows[i].st[k];
                c[6+k] = rows[i].en[k];
            end
            q = pack_query(c);
            want = predict_distance(q);
            if (rows[i].typed && want !== rows[i].res)
            begin
                $display("%0t: table row %0d expected %h predicted %h", $time, i,
                         rows[i].res, want);
                error_count++;
            end
            send_query(q);
        end

        // Pause until every directed result has come back.
        idle_sender(0);
        while (pending_results.size() != 0)
            @(negedge clk);

        burst_left = 0;
        for (int n = 0; n < 400; n++)
        begin
            q = random_query();
            // A stretch of back-to-back transfers around the receiver hold-off.
            if (hold_off)
                send_query(q);
            else
                send_with_gaps(q, burst_left);
        end
        idle_sender(0);
        stimulus_done = 1'b1;

        while (pending_results.size() != 0)
            @(negedge clk);
        settle = 0;
        while (settle < 2*LATENCY)
        begin
            @(negedge clk);
            settle++;
        end

        if (error_count == 0 && pending_results.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
